// ===== rtl/core/chm_pkg.sv =====
// Package for the chained hash map unit: sizes, operation and status codes,
// transaction structs, bucket row layout and controller command/status structs.
// No dependencies.
`default_nettype none

package chm_pkg;

    // Table geometry
    localparam int BUCKETS    = 127;
    localparam int SLOTS      = 8;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Fixed field widths of the transactions
    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W     = $clog2(SLOTS + 1);

    // Reciprocal for hash mod BUCKETS: q = (hash * MAGIC) >> MAG_SHIFT is exact
    // for every HASH_W-bit hash, the rounding error of MAGIC being below BUCKETS.
    localparam int MAGIC_W   = 32;
    localparam int MAG_SHIFT = HASH_W + $clog2(BUCKETS);
    localparam longint unsigned MAGIC_L =
        ((64'd1 << MAG_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_W'(MAGIC_L);
    localparam int PROD_W = HASH_W + MAGIC_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_ADD      = 3'd0;
    localparam logic [FUNC_W-1:0] OP_CONTAINS = 3'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE   = 3'd2;
    localparam logic [FUNC_W-1:0] OP_GET      = 3'd3;
    localparam logic [FUNC_W-1:0] OP_UPDATE   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  value_out;
    } rsp_t;

    // One bucket as stored in the row memory
    typedef struct packed {
        logic [SLOTS-1:0][KEY_BITS-1:0]   keys;
        logic [SLOTS-1:0][VALUE_BITS-1:0] values;
        logic [FILL_W-1:0]                fill;
    } row_t;

    typedef struct packed {
        logic accept;   // capture request, start hash multiply
        logic calc;     // reduce product to bucket index
        logic fetch;    // read bucket row
        logic commit;   // compare, write back, load result
    } dp_cmd_t;

    typedef struct packed {
        logic row_wr;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/chm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/chm_ctrl.sv =====
// Controller of the chained hash map unit: sequences one request through
// hash reduction, row read and commit, and owns the result valid flag. Uses chm_pkg.
`default_nettype none

module chm_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output chm_pkg::dp_cmd_t         cmd,
    input  wire chm_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit_ok;

    assign commit_ok = (state_reg == ST_CMP) && (!out_valid_reg || m_ready);

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.calc   = (state_reg == ST_MOD);
    assign cmd.fetch  = (state_reg == ST_RD);
    assign cmd.commit = commit_ok;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // hold until the result register is free
                if (commit_ok) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MOD))
        else $error("accepted transaction did not start the hash reduction");

    a_write_in_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        status.row_wr |-> (state_reg == ST_CMP) && commit_ok)
        else $error("bucket row written outside commit");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && out_valid_reg && !m_ready) |=> (state_reg == ST_CMP))
        else $error("commit overran an untaken result");

    a_commit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit did not present a result");

endmodule

`default_nettype wire

// ===== rtl/core/chm_dp.sv =====
// Datapath of the chained hash map unit: hash reduction, bucket row memory,
// slot compare, row update and result register. Uses chm_pkg and chm_ram.
`default_nettype none

module chm_dp (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire chm_pkg::req_t    s_payload,
    output chm_pkg::rsp_t         m_payload,
    input  wire chm_pkg::dp_cmd_t cmd,
    output chm_pkg::dp_status_t   status
);

    chm_pkg::req_t                      req_reg;
    logic [chm_pkg::PROD_W-1:0]         prod_reg;
    logic [chm_pkg::BKT_W-1:0]          bucket_reg, bucket_next;
    logic [chm_pkg::BUCKETS-1:0]        bucket_valid_reg;
    chm_pkg::rsp_t                      rsp_reg, rsp_next;

    logic [chm_pkg::HASH_W-1:0]         quot;
    logic [chm_pkg::HASH_W-1:0]         rem;

    chm_pkg::row_t                      row_rd, row_wr_data;
    logic                               row_wr;
    logic [chm_pkg::FILL_W-1:0]         fill;
    logic [chm_pkg::SLOTS-1:0]          hit_vec;
    logic [chm_pkg::SLOT_IDX_W-1:0]     hit_idx;
    logic                               found;
    logic [chm_pkg::FILL_W-1:0]         last;
    logic [chm_pkg::KEY_BITS-1:0]       req_key;
    logic [chm_pkg::VALUE_BITS-1:0]     req_val;

    // bucket = hash - BUCKETS * floor(hash * MAGIC >> MAG_SHIFT)
    assign quot = chm_pkg::HASH_W'(prod_reg >> chm_pkg::MAG_SHIFT);
    assign rem  = req_reg.key_hash - chm_pkg::HASH_W'(quot * chm_pkg::HASH_W'(chm_pkg::BUCKETS));
    assign bucket_next = chm_pkg::BKT_W'(rem);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg  <= s_payload;
            prod_reg <= chm_pkg::PROD_W'(s_payload.key_hash) * chm_pkg::PROD_W'(chm_pkg::MAGIC);
        end
        if (cmd.calc) begin
            bucket_reg <= bucket_next;
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    // a row never written reads as an empty bucket
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_valid_reg <= '0;
        end else if (row_wr) begin
            bucket_valid_reg[bucket_reg] <= 1'b1;
        end
    end

    chm_ram #(
        .WIDTH ($bits(chm_pkg::row_t)),
        .DEPTH (chm_pkg::BUCKETS)
    ) u_rows (
        .aclk    (aclk),
        .wr_en   (row_wr),
        .wr_addr (bucket_reg),
        .wr_data (row_wr_data),
        .rd_en   (cmd.fetch),
        .rd_addr (bucket_reg),
        .rd_data (row_rd)
    );

    assign req_key = chm_pkg::KEY_BITS'(req_reg.key);
    assign req_val = chm_pkg::VALUE_BITS'(req_reg.value);
    assign fill    = bucket_valid_reg[bucket_reg] ? row_rd.fill : '0;
    assign last    = fill - chm_pkg::FILL_W'(1);

    always_comb begin
        hit_vec = '0;
        hit_idx = '0;
        for (int i = 0; i < chm_pkg::SLOTS; i++) begin
            hit_vec[i] = (chm_pkg::FILL_W'(i) < fill) && (row_rd.keys[i] == req_key);
        end
        for (int i = chm_pkg::SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = chm_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    assign found = |hit_vec;

    always_comb begin
        logic modify;
        modify      = 1'b0;
        row_wr_data = row_rd;
        row_wr_data.fill = fill;
        rsp_next.status    = chm_pkg::ST_NOT_FOUND;
        rsp_next.found     = found;
        rsp_next.value_out = '0;
        case (req_reg.func)
            chm_pkg::OP_ADD: begin
                if (found) begin
                    rsp_next.status = chm_pkg::ST_PRESENT;
                end else if (fill == chm_pkg::FILL_W'(chm_pkg::SLOTS)) begin
                    rsp_next.status = chm_pkg::ST_FULL;
                end else begin
                    modify = 1'b1;
                    row_wr_data.keys[fill[chm_pkg::SLOT_IDX_W-1:0]]   = req_key;
                    row_wr_data.values[fill[chm_pkg::SLOT_IDX_W-1:0]] = req_val;
                    row_wr_data.fill = fill + chm_pkg::FILL_W'(1);
                    rsp_next.status  = chm_pkg::ST_DONE;
                end
            end
            chm_pkg::OP_CONTAINS: begin
                if (found) begin
                    rsp_next.status = chm_pkg::ST_DONE;
                end
            end
            chm_pkg::OP_DELETE: begin
                if (found) begin
                    modify = 1'b1;
                    row_wr_data.keys[hit_idx] =
                        row_rd.keys[last[chm_pkg::SLOT_IDX_W-1:0]];
                    row_wr_data.values[hit_idx] =
                        row_rd.values[last[chm_pkg::SLOT_IDX_W-1:0]];
                    row_wr_data.fill = last;
                    rsp_next.status  = chm_pkg::ST_DONE;
                end
            end
            chm_pkg::OP_GET: begin
                if (found) begin
                    rsp_next.status    = chm_pkg::ST_DONE;
                    rsp_next.value_out = chm_pkg::VALUE_W'(row_rd.values[hit_idx]);
                end
            end
            chm_pkg::OP_UPDATE: begin
                if (found) begin
                    modify = 1'b1;
                    row_wr_data.values[hit_idx] = req_val;
                    rsp_next.status = chm_pkg::ST_DONE;
                end
            end
            default: begin
                rsp_next.found = 1'b0;
            end
        endcase
        row_wr = cmd.commit && modify;
    end

    assign m_payload     = rsp_reg;
    assign status.row_wr = row_wr;

endmodule

`default_nettype wire

// ===== rtl/core/chained_hash_map_unit.sv =====
// Top level of the chained hash map unit: joins controller and datapath.
// Uses chm_pkg, chm_ctrl and chm_dp (which holds the chm_ram row memory).
`default_nettype none

// Key-value table with separate chaining. Each request transaction carries an
// operation (add, contains, delete, get, update), a key, the key's hash as
// computed outside the block, and a value; each gives exactly one result
// transaction of status, found flag and value. The bucket is key_hash mod
// BUCKETS, worked out with a reciprocal multiply in the cycle of acceptance and
// a reduction in the next. Each bucket is one row of the row memory holding
// all SLOTS keys and values and the fill count, so a request costs a single
// row read and at most one row write. A request steps through the multiply in the
// accepting cycle, then reduce, row read, and compare and write back, which loads
// the result register; s_ready rises again in the cycle the result appears, so
// the unit takes no new request before the last one has committed, this sequence
// running through the single row memory. A result waiting in the output
// register does not block the next request until that request reaches its
// commit step. Buckets hold at most SLOTS entries; an add of a new key to a
// full bucket answers "bucket full" and stores nothing. Reset empties every
// bucket at once through per-bucket valid flags, so there is no clearing pass.
module chained_hash_map_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire chm_pkg::req_t s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output chm_pkg::rsp_t      m_payload
);

    chm_pkg::dp_cmd_t    cmd;
    chm_pkg::dp_status_t status;

    // sequencing and result handshake
    chm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // hash reduction, row memory, compare and update
    chm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for chained_hash_map_unit: directed and random request
// transactions against a scoreboard that predicts each result transaction.
// Depends on chm_pkg and the RTL under rtl/core.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chm_pkg::*;

    // Spare operation codes: the block must answer them as "not found"
    localparam logic [FUNC_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [HASH_W-1:0]  HASH_MAX  = {HASH_W{1'b1}};
    localparam logic [KEY_W-1:0]   KEY_MAX   = {KEY_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    // Bucket that the all-ones hash selects
    localparam int FULL_BKT = int'(HASH_MAX % BUCKETS);

    localparam int RANDOM_ITEMS = 2000;  // requests with a real operation
    localparam int QUIET_ITEMS  = 200;   // tail of the run with no idling
    localparam int GROUP_LEN    = 100;   // requests per key pool / pressure setting
    localparam int DRAIN_CYCLES = 16;    // idle cycles after the last result
    localparam int CYCLE_LIMIT  = 400000;

    // ------------------------------------------------------------------
    // Scoreboard: shadow copy of the table plus the queue of results
    // still owed by the block.
    // ------------------------------------------------------------------
    class hash_map_scoreboard;
        logic [KEY_W-1:0]   slot_key [BUCKETS*SLOTS];
        logic [VALUE_W-1:0] slot_val [BUCKETS*SLOTS];
        int unsigned        fill     [BUCKETS];
        rsp_t               owed_q[$];
        int unsigned errors, n_req, n_rsp, n_stored, n_full, n_dup, n_del, n_get;

        function new();
            foreach (fill[i]) fill[i] = 0;
            errors = 0; n_req = 0; n_rsp = 0; n_stored = 0;
            n_full = 0; n_dup = 0; n_del = 0; n_get = 0;
        endfunction

        // Work out the result of one accepted request and update the shadow table
        function void note_request(req_t r);
            int unsigned bkt, base, cnt, hit, i;
            bit          hit_ok;
            rsp_t        e;
            bkt    = int'(r.key_hash % BUCKETS);
            base   = bkt * SLOTS;
            cnt    = fill[bkt];
            hit_ok = 1'b0;
            hit    = 0;
            for (i = 0; i < cnt; i++) begin
                if (!hit_ok && slot_key[base+i] == r.key) begin
                    hit_ok = 1'b1;
                    hit    = i;
                end
            end
            e.status    = ST_NOT_FOUND;
            e.found     = hit_ok;
            e.value_out = '0;
            case (r.func)
                OP_ADD: begin
                    if (hit_ok) begin
                        e.status = ST_PRESENT;
                        n_dup++;
                    end else if (cnt >= SLOTS) begin
                        e.status = ST_FULL;
                        n_full++;
                    end else begin
                        slot_key[base+cnt] = r.key;
                        slot_val[base+cnt] = r.value;
                        fill[bkt]          = cnt + 1;
                        e.status           = ST_DONE;
                        n_stored++;
                    end
                end
                OP_CONTAINS: begin
                    if (hit_ok) e.status = ST_DONE;
                end
                OP_DELETE: begin
                    if (hit_ok) begin
                        // last entry of the bucket fills the hole
                        slot_key[base+hit] = slot_key[base+cnt-1];
                        slot_val[base+hit] = slot_val[base+cnt-1];
                        fill[bkt]          = cnt - 1;
                        e.status           = ST_DONE;
                        n_del++;
                    end
                end
                OP_GET: begin
                    if (hit_ok) begin
                        e.value_out = slot_val[base+hit];
                        e.status    = ST_DONE;
                        n_get++;
                    end
                end
                OP_UPDATE: begin
                    if (hit_ok) begin
                        slot_val[base+hit] = r.value;
                        e.status           = ST_DONE;
                    end
                end
                default: begin
                    e.found = 1'b0;
                end
            endcase
            owed_q.push_back(e);
            n_req++;
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            n_rsp++;
            if (owed_q.size() == 0) begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.found !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, got.found);
                errors++;
            end
            if (got.value_out !== e.value_out) begin
                $error("value_out: expected %h, got %h", e.value_out, got.value_out);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------
    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_payload;
    logic m_valid;
    logic m_ready;
    rsp_t m_payload;

    hash_map_scoreboard sb;

    // Idling controls, changed per group of requests
    int unsigned send_gap_pct;
    int unsigned stall_pct;
    bit          quiet;
    int unsigned cycle_count;

    chained_hash_map_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // A fresh hash that lands in bucket bkt; the multiplier is drawn so the hash spans the full
    // 31-bit range and every hash bit toggles.
    function automatic logic [HASH_W-1:0] hash_in_bucket(int unsigned bkt);
        longint unsigned span;
        longint unsigned k;
        span = (longint'(HASH_MAX) - bkt) / BUCKETS;
        k    = $urandom_range(0, int'(span));
        return HASH_W'(bkt + k * BUCKETS);
    endfunction

    function automatic req_t make_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                          logic [HASH_W-1:0] h, logic [VALUE_W-1:0] v);
        req_t r;
        r.func     = f;
        r.key      = k;
        r.key_hash = h;
        r.value    = v;
        return r;
    endfunction

    // Offer one request transaction and hold it until accepted. Called at a
    // rising edge; valid is only lowered when a gap is inserted, so it never
    // toggles down and up within one step.
    task automatic send_request(input req_t r);
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Monitor: values read straight after the edge are those the block saw
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_payload);
            if (m_valid && m_ready) sb.check_result(m_payload);
        end
    end

    // Result side: ready with random stall bursts
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, sb.outstanding());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] pool_key[$];
        int unsigned      pool_bkt[$];
        int unsigned      grp_bkt[3];
        int unsigned      n_bkt, n_keys, sel, pick, meaningful, item_no, i;
        logic [KEY_W-1:0] k0, kabsent;
        req_t             r;

        sb           = new();
        send_gap_pct = 20;
        stall_pct    = 20;
        quiet        = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- Directed part ---
        // Bucket 0: extreme keys, values and the zero hash
        k0      = '0;
        kabsent = 32'h1234_5678;
        send_request(make_request(OP_ADD,      k0,      '0,                VALUE_W'(0)));
        send_request(make_request(OP_ADD,      KEY_MAX, hash_in_bucket(0), VALUE_MAX));
        send_request(make_request(OP_ADD,      k0,      '0,                $urandom));
        send_request(make_request(OP_CONTAINS, k0,      hash_in_bucket(0), $urandom));
        send_request(make_request(OP_CONTAINS, kabsent, hash_in_bucket(0), $urandom));
        send_request(make_request(OP_GET,      KEY_MAX, hash_in_bucket(0), $urandom));
        send_request(make_request(OP_UPDATE,   k0,      '0,                $urandom));
        send_request(make_request(OP_GET,      k0,      '0,                $urandom));
        // deleting slot 0 pulls the last entry down into it
        send_request(make_request(OP_DELETE,   k0,      '0,                $urandom));
        send_request(make_request(OP_GET,      KEY_MAX, '0,                $urandom));
        // misses after the delete
        send_request(make_request(OP_DELETE,   k0,      '0,                $urandom));
        send_request(make_request(OP_GET,      k0,      '0,                $urandom));
        send_request(make_request(OP_UPDATE,   k0,      '0,                VALUE_MAX));
        // spare codes touch nothing, even with a stored key
        for (i = OP_SPARE_5; i <= OP_SPARE_7; i++)
            send_request(make_request(FUNC_W'(i), KEY_MAX, '0, VALUE_MAX));
        // Fill the bucket of the all-ones hash, overflow it, then delete its first entry
        for (i = 0; i <= SLOTS; i++)
            send_request(make_request(OP_ADD, 32'hA5A5_0000 + i,
                                      i[0] ? HASH_MAX : HASH_W'(FULL_BKT), $urandom));
        send_request(make_request(OP_DELETE, 32'hA5A5_0000, HASH_MAX, $urandom));
        send_request(make_request(OP_GET, 32'hA5A5_0000 + SLOTS - 1, HASH_MAX, $urandom));

        // --- Random part ---
        // Keys come from a small pool tied to one to three buckets so that
        // buckets fill, overflow and shuffle on delete; one in ten requests
        // is noise with a random key and hash.
        meaningful = 0;
        item_no    = 0;
        while (meaningful < RANDOM_ITEMS) begin
            if (item_no % GROUP_LEN == 0) begin
                pool_key.delete();
                pool_bkt.delete();
                n_bkt  = $urandom_range(1, 3);
                n_keys = $urandom_range(4, 20);
                foreach (grp_bkt[j]) grp_bkt[j] = $urandom_range(0, BUCKETS - 1);
                for (i = 0; i < n_keys; i++) begin
                    pool_key.push_back($urandom);
                    pool_bkt.push_back(grp_bkt[$urandom_range(0, n_bkt - 1)]);
                end
                case ($urandom_range(0, 2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 15;
                    default: send_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            if (meaningful >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 35)      r.func = OP_ADD;
            else if (pick < 47) r.func = OP_CONTAINS;
            else if (pick < 65) r.func = OP_DELETE;
            else if (pick < 83) r.func = OP_GET;
            else if (pick < 95) r.func = OP_UPDATE;
            else                r.func = FUNC_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            if ($urandom_range(0, 9) == 0) begin
                r.key      = $urandom;
                r.key_hash = HASH_W'($urandom);
            end else begin
                sel        = $urandom_range(0, pool_key.size() - 1);
                r.key      = pool_key[sel];
                r.key_hash = hash_in_bucket(pool_bkt[sel]);
            end
            r.value = $urandom;
            send_request(r);
            if (r.func <= OP_UPDATE) meaningful++;
            item_no++;
        end
        s_valid <= 1'b0;

        // Drain the owed results, then give the block a few idle cycles
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests, %0d results checked: %0d stored, %0d duplicate adds,",
                 sb.n_req, sb.n_rsp, sb.n_stored, sb.n_dup);
        $display("%0d adds to full buckets, %0d deletes and %0d gets that hit; %0d errors",
                 sb.n_full, sb.n_del, sb.n_get, sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
